[hdl/tmbe_pkg.sv]
// ----------------------------------------------------------------------------
// tmbe_pkg
// Instruction codes, status codes and fixed widths of the tape machine
// bytecode executor.
// ----------------------------------------------------------------------------
`default_nettype none

package tmbe_pkg;

    localparam int INSTR_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int REP_W    = 9;
    localparam int DIST_W   = 29;

    localparam logic [1:0] KIND_ADD  = 2'b00;
    localparam logic [1:0] KIND_MOVE = 2'b01;
    localparam logic [1:0] KIND_JUMP = 2'b10;
    localparam logic [1:0] KIND_SYS  = 2'b11;

    localparam logic [15:0] OP_READ   = 16'hC000;
    localparam logic [15:0] OP_CLEAR  = 16'hC001;
    localparam logic [15:0] OP_SCAN_R = 16'hC002;
    localparam logic [15:0] OP_SCAN_L = 16'hC003;
    localparam logic [15:0] OP_BREAK  = 16'hC004;
    localparam logic [15:0] OP_HALT   = 16'hDEAD;

    localparam logic [2:0] GRP_ARG   = 3'b111;
    localparam logic [4:0] ARG_OUT   = 5'h00;
    localparam logic [4:0] ARG_ADD_R = 5'h01;
    localparam logic [4:0] ARG_ADD_L = 5'h02;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_HALT    = 3'd1,
        ST_BREAK   = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

endpackage

`default_nettype wire

[hdl/tape_machine_bytecode_executor_unit.sv]
// ----------------------------------------------------------------------------
// tape_machine_bytecode_executor_unit
// Executes one compiled tape-machine instruction per input transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries the instruction word, the
// extension word of a long jump and the byte for the read instruction.
// Output channel (out_valid/out_ready) carries the next program counter,
// the output byte with its repeat count, the input-taken flag and status.
// A small sequencer drives one tape memory with a read port and a write
// port: one read a cycle with registered data, one write a cycle.
// Each instruction goes from acceptance through an execute state to a
// finish state; neighbour add also reads the target, writes the target
// and clears the cell, and the scans step cell by cell. One instruction
// is in flight at a time; in_ready returns in the cycle that out_valid
// rises, so a new transaction is taken only after the last one finishes.
// After reset the tape is cleared one cell a cycle, with in_ready low
// until every cell is clear. The pointer and program counter reset to zero.
// If the receiver stalls, a finished result holds in the output register
// and the next instruction may be accepted; its result waits until the
// output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_machine_bytecode_executor_unit #(
    parameter int TAPE_CELLS = 32768,
    parameter int CELL_BITS  = 8,
    parameter int PC_BITS    = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tmbe_pkg::INSTR_W-1:0]  instr_word,
    input  wire logic [tmbe_pkg::INSTR_W-1:0]  ext_word,
    input  wire logic [tmbe_pkg::BYTE_W-1:0]   in_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [PC_BITS-1:0]                 next_pc,
    output logic [tmbe_pkg::BYTE_W-1:0]        out_byte,
    output logic [tmbe_pkg::REP_W-1:0]         out_repeat,
    output logic                               input_taken,
    output logic [2:0]                         status
);

    localparam int PTR_W = $clog2(TAPE_CELLS);
    localparam int MV_W  = ((PTR_W > 14) ? PTR_W : 14) + 2;
    localparam int NB_W  = PTR_W + 2;
    localparam int DIST_LOCAL_W = tmbe_pkg::DIST_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_NB_ADD,
        S_NB_CLR,
        S_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]                ptr_reg, ptr_next;
    logic [PC_BITS-1:0]              pc_reg, pc_next;
    logic [tmbe_pkg::INSTR_W-1:0]    instr_reg, instr_next;
    logic [tmbe_pkg::INSTR_W-1:0]    ext_reg, ext_next;
    logic [tmbe_pkg::BYTE_W-1:0]     inb_reg, inb_next;
    logic [PTR_W-1:0]                scan_ptr_reg, scan_ptr_next;
    logic [PTR_W-1:0]                nb_addr_reg, nb_addr_next;
    logic [CELL_BITS-1:0]            cell_save_reg, cell_save_next;
    logic [tmbe_pkg::BYTE_W-1:0]     res_ob_reg, res_ob_next;
    logic [tmbe_pkg::REP_W-1:0]      res_rep_reg, res_rep_next;
    logic                            res_taken_reg, res_taken_next;
    tmbe_pkg::status_t               res_st_reg, res_st_next;
    logic                            out_valid_reg, out_valid_next;
    logic [PC_BITS-1:0]              out_pc_reg, out_pc_next;
    logic [tmbe_pkg::BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic [tmbe_pkg::REP_W-1:0]      out_rep_reg, out_rep_next;
    logic                            out_taken_reg, out_taken_next;
    tmbe_pkg::status_t               out_st_reg, out_st_next;

    logic [CELL_BITS-1:0]            tape_mem [TAPE_CELLS];
    logic [CELL_BITS-1:0]            rd_data_reg;
    logic                            mem_we;
    logic [PTR_W-1:0]                mem_waddr;
    logic [PTR_W-1:0]                mem_raddr;
    logic [CELL_BITS-1:0]            mem_wdata;

    logic                            acc_long;
    logic signed [MV_W-1:0]          mv_pos;
    logic                            mv_bad;
    logic signed [NB_W-1:0]          nb_pos;
    logic                            nb_bad;
    logic                            nb_op;
    logic [DIST_LOCAL_W-1:0]         dist_full;
    logic [PC_BITS-1:0]              dist_pc;
    logic                            jmp_take;
    logic [CELL_BITS-1:0]            add_delta;
    logic                            scan_right;
    logic                            scan_end;
    logic [PTR_W-1:0]                scan_step;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tape_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tape_mem[mem_raddr];
    end

    always_comb
    begin
        acc_long   = (instr_word[15:14] == tmbe_pkg::KIND_JUMP) && instr_word[12];

        mv_pos     = signed'(MV_W'(ptr_reg)) + MV_W'(signed'(instr_reg[13:0]));
        mv_bad     = mv_pos[MV_W-1] || (mv_pos >= signed'(MV_W'(TAPE_CELLS)));

        nb_op      = (instr_reg[15:13] == tmbe_pkg::GRP_ARG)
                     && ((instr_reg[12:8] == tmbe_pkg::ARG_ADD_R)
                         || (instr_reg[12:8] == tmbe_pkg::ARG_ADD_L));
        if (instr_reg[12:8] == tmbe_pkg::ARG_ADD_R)
        begin
            nb_pos = signed'(NB_W'(ptr_reg)) + signed'(NB_W'(instr_reg[7:0]));
        end
        else
        begin
            nb_pos = signed'(NB_W'(ptr_reg)) - signed'(NB_W'(instr_reg[7:0]));
        end
        nb_bad     = nb_pos[NB_W-1] || (nb_pos >= signed'(NB_W'(TAPE_CELLS)));

        if (instr_reg[12])
        begin
            dist_full = DIST_LOCAL_W'({instr_reg[11:0], ext_reg}) + DIST_LOCAL_W'(1);
        end
        else
        begin
            dist_full = DIST_LOCAL_W'(instr_reg[11:0]);
        end
        dist_pc    = dist_full[PC_BITS-1:0];
        jmp_take   = ((rd_data_reg != '0) == instr_reg[13]);

        add_delta  = CELL_BITS'(signed'(instr_reg[13:0]));

        scan_right = (instr_reg == tmbe_pkg::OP_SCAN_R);
        scan_end   = scan_right ? (scan_ptr_reg == PTR_W'(TAPE_CELLS - 1))
                                : (scan_ptr_reg == '0);
        scan_step  = scan_right ? (scan_ptr_reg + PTR_W'(1))
                                : (scan_ptr_reg - PTR_W'(1));
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  mem_raddr = ptr_reg;
            S_EXEC:  mem_raddr = nb_op ? nb_pos[PTR_W-1:0] : ptr_reg;
            S_SCAN:  mem_raddr = scan_step;
            default: mem_raddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ptr_next       = ptr_reg;
        pc_next        = pc_reg;
        instr_next     = instr_reg;
        ext_next       = ext_reg;
        inb_next       = inb_reg;
        scan_ptr_next  = scan_ptr_reg;
        nb_addr_next   = nb_addr_reg;
        cell_save_next = cell_save_reg;
        res_ob_next    = res_ob_reg;
        res_rep_next   = res_rep_reg;
        res_taken_next = res_taken_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_pc_next    = out_pc_reg;
        out_byte_next  = out_byte_reg;
        out_rep_next   = out_rep_reg;
        out_taken_next = out_taken_reg;
        out_st_next    = out_st_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == PTR_W'(TAPE_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + PTR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    instr_next     = instr_word;
                    ext_next       = ext_word;
                    inb_next       = in_byte;
                    pc_next        = pc_reg + (acc_long ? PC_BITS'(2) : PC_BITS'(1));
                    scan_ptr_next  = ptr_reg;
                    res_ob_next    = '0;
                    res_rep_next   = '0;
                    res_taken_next = 1'b0;
                    res_st_next    = tmbe_pkg::ST_RUN;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FIN;
                unique case (instr_reg[15:14])
                    tmbe_pkg::KIND_ADD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_data_reg + add_delta;
                    end
                    tmbe_pkg::KIND_MOVE:
                    begin
                        if (mv_bad)
                        begin
                            res_st_next = tmbe_pkg::ST_CORRUPT;
                        end
                        else
                        begin
                            ptr_next = mv_pos[PTR_W-1:0];
                        end
                    end
                    tmbe_pkg::KIND_JUMP:
                    begin
                        if (jmp_take)
                        begin
                            pc_next = instr_reg[13] ? (pc_reg - dist_pc)
                                                    : (pc_reg + dist_pc);
                        end
                    end
                    tmbe_pkg::KIND_SYS:
                    begin
                        unique case (instr_reg)
                            tmbe_pkg::OP_HALT:
                                res_st_next = tmbe_pkg::ST_HALT;
                            tmbe_pkg::OP_READ:
                            begin
                                mem_we         = 1'b1;
                                mem_wdata      = CELL_BITS'(inb_reg);
                                res_taken_next = 1'b1;
                            end
                            tmbe_pkg::OP_CLEAR:
                                mem_we = 1'b1;
                            tmbe_pkg::OP_SCAN_R,
                            tmbe_pkg::OP_SCAN_L:
                                state_next = S_SCAN;
                            tmbe_pkg::OP_BREAK:
                                res_st_next = tmbe_pkg::ST_BREAK;
                            default:
                            begin
                                if (instr_reg[15:13] != tmbe_pkg::GRP_ARG)
                                begin
                                    res_st_next = tmbe_pkg::ST_UNKNOWN;
                                end
                                else if (instr_reg[12:8] == tmbe_pkg::ARG_OUT)
                                begin
                                    res_ob_next  = rd_data_reg[tmbe_pkg::BYTE_W-1:0];
                                    res_rep_next = {1'b0, instr_reg[7:0]}
                                                   + tmbe_pkg::REP_W'(1);
                                end
                                else if (nb_op)
                                begin
                                    if (nb_bad)
                                    begin
                                        res_st_next = tmbe_pkg::ST_CORRUPT;
                                    end
                                    else
                                    begin
                                        cell_save_next = rd_data_reg;
                                        nb_addr_next   = nb_pos[PTR_W-1:0];
                                        state_next     = S_NB_ADD;
                                    end
                                end
                                else
                                begin
                                    res_st_next = tmbe_pkg::ST_UNKNOWN;
                                end
                            end
                        endcase
                    end
                endcase
            end

            S_SCAN:
            begin
                if (rd_data_reg == '0)
                begin
                    ptr_next   = scan_ptr_reg;
                    state_next = S_FIN;
                end
                else if (scan_end)
                begin
                    res_st_next = tmbe_pkg::ST_CORRUPT;
                    state_next  = S_FIN;
                end
                else
                begin
                    scan_ptr_next = scan_step;
                end
            end

            S_NB_ADD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = nb_addr_reg;
                mem_wdata  = rd_data_reg + cell_save_reg;
                state_next = S_NB_CLR;
            end

            S_NB_CLR:
            begin
                mem_we     = 1'b1;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pc_next    = pc_reg;
                    out_byte_next  = res_ob_reg;
                    out_rep_next   = res_rep_reg;
                    out_taken_next = res_taken_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            ptr_reg       <= '0;
            pc_reg        <= '0;
            instr_reg     <= '0;
            ext_reg       <= '0;
            inb_reg       <= '0;
            scan_ptr_reg  <= '0;
            nb_addr_reg   <= '0;
            cell_save_reg <= '0;
            res_ob_reg    <= '0;
            res_rep_reg   <= '0;
            res_taken_reg <= 1'b0;
            res_st_reg    <= tmbe_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
            out_pc_reg    <= '0;
            out_byte_reg  <= '0;
            out_rep_reg   <= '0;
            out_taken_reg <= 1'b0;
            out_st_reg    <= tmbe_pkg::ST_RUN;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ptr_reg       <= ptr_next;
            pc_reg        <= pc_next;
            instr_reg     <= instr_next;
            ext_reg       <= ext_next;
            inb_reg       <= inb_next;
            scan_ptr_reg  <= scan_ptr_next;
            nb_addr_reg   <= nb_addr_next;
            cell_save_reg <= cell_save_next;
            res_ob_reg    <= res_ob_next;
            res_rep_reg   <= res_rep_next;
            res_taken_reg <= res_taken_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            out_pc_reg    <= out_pc_next;
            out_byte_reg  <= out_byte_next;
            out_rep_reg   <= out_rep_next;
            out_taken_reg <= out_taken_next;
            out_st_reg    <= out_st_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign next_pc     = out_pc_reg;
    assign out_byte    = out_byte_reg;
    assign out_repeat  = out_rep_reg;
    assign input_taken = out_taken_reg;
    assign status      = out_st_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in flight");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ptr_reg} < (PTR_W + 1)'(TAPE_CELLS)))
        else $error("cell pointer beyond tape");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && input_taken) |->
            (status == 3'(tmbe_pkg::ST_RUN) && out_repeat == '0))
        else $error("read result carries output or fault");

    a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_repeat != '0) |-> (status == 3'(tmbe_pkg::ST_RUN)))
        else $error("output transaction with non-running status");

endmodule

`default_nettype wire

[tb/tape_machine_bytecode_executor_unit_test.sv]
// ----------------------------------------------------------------------------
// tape_machine_bytecode_executor_unit_test
// Testbench for the tape-machine bytecode executor. Directed instructions
// cover the field extremes, every instruction and the fault cases at the
// tape edges, left neighbour add excepted. A long run of random instructions
// follows. A shadow tape, cell pointer and program counter predict every
// result, and each output transaction is compared field by field. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_machine_bytecode_executor_unit_test;

    localparam int TAPE_CELLS   = 32768;
    localparam int CELL_BITS    = 8;
    localparam int PC_BITS      = 20;
    localparam int RANDOM_ITEMS = 1100;
    localparam int BURST_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [PC_BITS-1:0]          next_pc;
        logic [tmbe_pkg::BYTE_W-1:0] out_byte;
        logic [tmbe_pkg::REP_W-1:0]  out_repeat;
        logic                        input_taken;
        tmbe_pkg::status_t           status;
    } step_result_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic [tmbe_pkg::INSTR_W-1:0]   instr_word  = '0;
    logic [tmbe_pkg::INSTR_W-1:0]   ext_word    = '0;
    logic [tmbe_pkg::BYTE_W-1:0]    in_byte     = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [PC_BITS-1:0]             next_pc;
    logic [tmbe_pkg::BYTE_W-1:0]    out_byte;
    logic [tmbe_pkg::REP_W-1:0]     out_repeat;
    logic                           input_taken;
    logic [2:0]                     status;

    logic [CELL_BITS-1:0] shadow_tape [TAPE_CELLS];
    int                   shadow_ptr  = 0;
    logic [PC_BITS-1:0]   shadow_pc   = '0;
    step_result_t         pending_results [$];

    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int status_hits [5] = '{default: 0};
    int cycle_count     = 0;
    bit no_idle         = 1'b0;
    bit hold_req        = 1'b0;

    tape_machine_bytecode_executor_unit #(
        .TAPE_CELLS (TAPE_CELLS),
        .CELL_BITS  (CELL_BITS),
        .PC_BITS    (PC_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .instr_word  (instr_word),
        .ext_word    (ext_word),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .next_pc     (next_pc),
        .out_byte    (out_byte),
        .out_repeat  (out_repeat),
        .input_taken (input_taken),
        .status      (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run stopped after %0d cycles without finishing", $time, CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic step_result_t execute_instr(
        input logic [tmbe_pkg::INSTR_W-1:0] w,
        input logic [tmbe_pkg::INSTR_W-1:0] ext,
        input logic [tmbe_pkg::BYTE_W-1:0]  inb);
        step_result_t                r;
        logic [PC_BITS-1:0]          pc;
        logic [tmbe_pkg::DIST_W-1:0] jmp_dist;
        int                          offs;
        int                          tgt;
        int                          p;
        pc            = shadow_pc + PC_BITS'(1);
        r.next_pc     = '0;
        r.out_byte    = '0;
        r.out_repeat  = '0;
        r.input_taken = 1'b0;
        r.status      = tmbe_pkg::ST_RUN;
        offs          = int'($signed(w[13:0]));
        case (w[15:14])
            tmbe_pkg::KIND_ADD:
                shadow_tape[shadow_ptr] = shadow_tape[shadow_ptr] + offs[CELL_BITS-1:0];
            tmbe_pkg::KIND_MOVE:
            begin
                tgt = shadow_ptr + offs;
                if (tgt < 0 || tgt >= TAPE_CELLS)
                    r.status = tmbe_pkg::ST_CORRUPT;
                else
                    shadow_ptr = tgt;
            end
            tmbe_pkg::KIND_JUMP:
            begin
                jmp_dist = tmbe_pkg::DIST_W'(w[11:0]);
                if (w[12])
                begin
                    jmp_dist = {1'b0, w[11:0], ext} + tmbe_pkg::DIST_W'(1);
                    pc       = pc + PC_BITS'(1);
                end
                if ((shadow_tape[shadow_ptr] != 0) == w[13])
                    pc = w[13] ? pc - jmp_dist[PC_BITS-1:0] : pc + jmp_dist[PC_BITS-1:0];
            end
            default:
            begin
                if (w[15:13] == tmbe_pkg::OP_READ[15:13])
                begin
                    if (w == tmbe_pkg::OP_HALT)
                        r.status = tmbe_pkg::ST_HALT;
                    else if (w == tmbe_pkg::OP_READ)
                    begin
                        shadow_tape[shadow_ptr] = inb;
                        r.input_taken = 1'b1;
                    end
                    else if (w == tmbe_pkg::OP_CLEAR)
                        shadow_tape[shadow_ptr] = '0;
                    else if (w == tmbe_pkg::OP_SCAN_R)
                    begin
                        p = shadow_ptr;
                        while (p < TAPE_CELLS - 1 && shadow_tape[p] != 0)
                            p++;
                        if (shadow_tape[p] != 0)
                            r.status = tmbe_pkg::ST_CORRUPT;
                        else
                            shadow_ptr = p;
                    end
                    else if (w == tmbe_pkg::OP_SCAN_L)
                    begin
                        p = shadow_ptr;
                        while (p > 0 && shadow_tape[p] != 0)
                            p--;
                        if (shadow_tape[p] != 0)
                            r.status = tmbe_pkg::ST_CORRUPT;
                        else
                            shadow_ptr = p;
                    end
                    else if (w == tmbe_pkg::OP_BREAK)
                        r.status = tmbe_pkg::ST_BREAK;
                    else
                        r.status = tmbe_pkg::ST_UNKNOWN;
                end
                else if (w[12:8] == tmbe_pkg::ARG_OUT)
                begin
                    r.out_byte   = shadow_tape[shadow_ptr];
                    r.out_repeat = tmbe_pkg::REP_W'(w[7:0]) + tmbe_pkg::REP_W'(1);
                end
                else if (w[12:8] == tmbe_pkg::ARG_ADD_R || w[12:8] == tmbe_pkg::ARG_ADD_L)
                begin
                    tgt = (w[12:8] == tmbe_pkg::ARG_ADD_R) ? shadow_ptr + int'(w[7:0])
                                                           : shadow_ptr - int'(w[7:0]);
                    if (tgt < 0 || tgt >= TAPE_CELLS)
                        r.status = tmbe_pkg::ST_CORRUPT;
                    else
                    begin
                        shadow_tape[tgt]        = shadow_tape[tgt] + shadow_tape[shadow_ptr];
                        shadow_tape[shadow_ptr] = '0;
                    end
                end
                else
                    r.status = tmbe_pkg::ST_UNKNOWN;
            end
        endcase
        shadow_pc = pc;
        r.next_pc = pc;
        return r;
    endfunction

    function automatic int idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (no_idle || sel < 60)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [tmbe_pkg::INSTR_W-1:0] pick_instr();
        int          sel;
        logic [13:0] low;
        logic [7:0]  arg;
        sel = $urandom_range(0, 99);
        low = 14'($urandom);
        arg = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8)) : 8'($urandom);
        if (sel < 18)
            return {tmbe_pkg::KIND_ADD, ($urandom_range(0, 3) == 0) ? low
                                : 14'(int'($urandom_range(0, 15)) - 7)};
        if (sel < 32)
            return {tmbe_pkg::KIND_MOVE, ($urandom_range(0, 9) == 0) ? low
                                : 14'(int'($urandom_range(0, 8)) - 4)};
        if (sel < 46)
            return {tmbe_pkg::KIND_JUMP, low};
        if (sel < 54)
            return tmbe_pkg::OP_READ;
        if (sel < 58)
            return tmbe_pkg::OP_CLEAR;
        if (sel < 62)
            return tmbe_pkg::OP_SCAN_R;
        if (sel < 66)
            return tmbe_pkg::OP_SCAN_L;
        if (sel < 68)
            return tmbe_pkg::OP_BREAK;
        if (sel < 70)
            return tmbe_pkg::OP_HALT;
        if (sel < 73)
            return {tmbe_pkg::OP_READ[15:13], 13'($urandom)};
        if (sel < 81)
            return {tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_OUT, 8'($urandom)};
        if (sel < 87)
            return {tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_ADD_R, arg};
        if (sel < 92)
            return {tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_ADD_L, arg};
        if (sel < 95)
            return {tmbe_pkg::GRP_ARG, 5'($urandom_range(3, 31)), 8'($urandom)};
        return 16'($urandom);
    endfunction

    task automatic send_instr(input logic [tmbe_pkg::INSTR_W-1:0] w,
                              input logic [tmbe_pkg::INSTR_W-1:0] ext,
                              input logic [tmbe_pkg::BYTE_W-1:0]  inb);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        instr_word <= w;
        ext_word   <= ext;
        in_byte    <= inb;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(execute_instr(w, ext, inb));
        items_sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_instr();
        send_instr(pick_instr(), 16'($urandom), 8'($urandom));
    endtask

    task automatic check_field(input string what, input logic [19:0] want,
                               input logic [19:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each output transaction with the oldest prediction.
    always @(posedge clk)
    begin
        step_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending, next_pc %h status %0d",
                         $time, next_pc, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("next_pc", 20'(want.next_pc), 20'(next_pc));
                check_field("out_byte", 20'(want.out_byte), 20'(out_byte));
                check_field("out_repeat", 20'(want.out_repeat), 20'(out_repeat));
                check_field("input_taken", 20'(want.input_taken), 20'(input_taken));
                check_field("status", 20'(want.status), 20'(status));
                status_hits[want.status]++;
                results_checked++;
            end
        end
    end

    initial
    begin : receiver
        int stall;
        int sel;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (no_idle)
                stall = 0;
            else if (stall == 0)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    stall = $urandom_range(1, 3);
                else if (sel < 18)
                    stall = $urandom_range(10, 40);
            end
            out_ready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    task automatic test_cell_arith();
        send_instr({tmbe_pkg::KIND_ADD, 14'h1FFF}, 16'hFFFF, 8'hFF);
        send_instr({tmbe_pkg::KIND_ADD, 14'h2000}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_OUT, 8'hFF}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_ADD, 14'h0000}, 16'h0000, 8'h00);
        send_instr(tmbe_pkg::OP_CLEAR, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_OUT, 8'h00}, 16'h0000, 8'h00);
    endtask

    task automatic test_jumps();
        send_instr({tmbe_pkg::KIND_JUMP, 2'b00, 12'hFFF}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_JUMP, 2'b10, 12'h005}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_JUMP, 2'b01, 12'hFFF}, 16'hFFFF, 8'h00);
        send_instr({tmbe_pkg::KIND_ADD, 14'h0001}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_JUMP, 2'b11, 12'h000}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_JUMP, 2'b10, 12'hFFF}, 16'h0000, 8'h00);
    endtask

    task automatic test_sys_ops();
        send_instr(tmbe_pkg::OP_READ, 16'h0000, 8'hFF);
        send_instr(tmbe_pkg::OP_BREAK, 16'h0000, 8'h00);
        send_instr(tmbe_pkg::OP_HALT, 16'h0000, 8'h00);
        send_instr(tmbe_pkg::OP_BREAK + 16'd1, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::GRP_ARG, 5'h1F, 8'hFF}, 16'h0000, 8'h00);
    endtask

    // Pointer sits on cell 0, which now holds a nonzero value.
    task automatic test_pointer_limits();
        send_instr({tmbe_pkg::KIND_MOVE, 14'h3FFF}, 16'h0000, 8'h00);
        send_instr(tmbe_pkg::OP_SCAN_L, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_ADD_R, 8'h00}, 16'h0000, 8'h00);
    endtask

    task automatic test_tape_end();
        repeat (4) send_instr({tmbe_pkg::KIND_MOVE, 14'h1FFF}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_MOVE, 14'h0003}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_ADD, 14'h0005}, 16'h0000, 8'h00);
        send_instr(tmbe_pkg::OP_SCAN_R, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_MOVE, 14'h1FFF}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::GRP_ARG, tmbe_pkg::ARG_ADD_R, 8'h01}, 16'h0000, 8'h00);
        send_instr({tmbe_pkg::KIND_MOVE, 14'h2000}, 16'h0000, 8'h00);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (BURST_ITEMS) send_random_instr();
        no_idle = 1'b0;
    endtask

    // Hold the receiver off and offer twelve transactions back to back, so input stalls.
    task automatic test_backpressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (12) send_random_instr();
        no_idle  = 1'b0;
    endtask

    task automatic test_random_programs();
        repeat (RANDOM_ITEMS) send_random_instr();
    endtask

    initial
    begin
        foreach (shadow_tape[i])
            shadow_tape[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_cell_arith();
        test_jumps();
        test_sys_ops();
        test_pointer_limits();
        test_tape_end();
        test_back_to_back();
        test_backpressure();
        test_random_programs();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Executed %0d instructions, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatch_count);
        $display("Seen: %0d halts, %0d breakpoints, %0d corruption faults, %0d unknown codes",
                 status_hits[tmbe_pkg::ST_HALT], status_hits[tmbe_pkg::ST_BREAK],
                 status_hits[tmbe_pkg::ST_CORRUPT], status_hits[tmbe_pkg::ST_UNKNOWN]);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/tmbe_pkg.sv
hdl/tape_machine_bytecode_executor_unit.sv
tb/tape_machine_bytecode_executor_unit_test.sv
